FILE: hw/rtl/vdd_pkg.sv
// vdd_pkg: shared constants, mode codes and controller/datapath interface types
// for the vector distance and dot product block. depends on nothing.

package vdd_pkg;

   localparam int COMPONENT_WIDTH_DEF = 16;
   localparam int ACC_WIDTH           = 42;
   localparam int CSR_WIDTH           = 2;

   localparam logic [CSR_WIDTH-1:0] MODE_DIST = 2'd0;
   localparam logic [CSR_WIDTH-1:0] MODE_DOT  = 2'd1;
   localparam logic [CSR_WIDTH-1:0] MODE_NORM = 2'd2;

   typedef struct packed {
      logic accept;       // input beat taken this cycle
      logic finish;       // close the vector held in the term stage
      logic root_step;    // one square root iteration
   } cmd_type;

   typedef struct packed {
      logic last_pending; // term stage holds the closing term
      logic needs_root;   // that term was taken in distance or norm mode
      logic root_last;    // current iteration is the final one
   } status_type;

endpackage

FILE: hw/rtl/vdd_datapath.sv
// vdd_datapath: mode register, shared multiplier, term stage, accumulator,
// iterative square root and result register. depends on vdd_pkg.

module vdd_datapath #(
   parameter int COMPONENT_WIDTH = vdd_pkg::COMPONENT_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [vdd_pkg::CSR_WIDTH-1:0]          csr_wdata,
   input  logic signed [COMPONENT_WIDTH-1:0]      comp_a,
   input  logic signed [COMPONENT_WIDTH-1:0]      comp_b,
   input  logic                                   last,
   input  vdd_pkg::cmd_type                       cmd,
   output vdd_pkg::status_type                    status,
   output logic [vdd_pkg::ACC_WIDTH-1:0]          result
);
   import vdd_pkg::*;

   localparam int OP_W   = COMPONENT_WIDTH + 1;
   localparam int PROD_W = 2 * OP_W;

   logic [CSR_WIDTH-1:0]      op_mode_ff, op_mode_in;
   logic signed [OP_W-1:0]    ext_a, ext_b, diff, op_x, op_y;
   logic signed [PROD_W-1:0]  product;

   logic                      term_valid_ff, term_valid_in;
   logic                      term_last_ff, term_last_in;
   logic                      term_root_ff, term_root_in;
   logic [ACC_WIDTH-1:0]      term_ff, term_in;
   logic [ACC_WIDTH-1:0]      acc_ff, acc_in;
   logic [ACC_WIDTH-1:0]      sum;

   logic [ACC_WIDTH-1:0]      rem_ff, rem_in;
   logic [ACC_WIDTH-1:0]      root_ff, root_in;
   logic [ACC_WIDTH-1:0]      bit_ff, bit_in;
   logic [ACC_WIDTH-1:0]      trial, root_next;
   logic                      fits;
   logic [ACC_WIDTH-1:0]      result_ff, result_in;

   assign ext_a = OP_W'(comp_a);
   assign ext_b = OP_W'(comp_b);
   assign diff  = ext_a - ext_b;

   always_comb begin
      unique case (op_mode_ff)
         MODE_DIST: begin
            op_x = diff;
            op_y = diff;
         end
         MODE_DOT: begin
            op_x = ext_a;
            op_y = ext_b;
         end
         default: begin
            op_x = ext_a;
            op_y = ext_a;
         end
      endcase
   end

   assign product = op_x * op_y;
   assign sum     = acc_ff + term_ff;

   // one restoring square root step, two bits of the radicand per cycle while root_step is set
   assign trial     = root_ff + bit_ff;
   assign fits      = rem_ff >= trial;
   assign root_next = fits ? ((root_ff >> 1) + bit_ff) : (root_ff >> 1);

   always_comb begin
      op_mode_in    = csr_we ? csr_wdata : op_mode_ff;
      term_valid_in = cmd.accept || (term_valid_ff && term_last_ff && !cmd.finish);
      term_last_in  = term_last_ff;
      term_root_in  = term_root_ff;
      term_in       = term_ff;
      acc_in        = acc_ff;
      rem_in        = rem_ff;
      root_in       = root_ff;
      bit_in        = bit_ff;
      result_in     = result_ff;

      if (cmd.accept) begin
         term_in      = ACC_WIDTH'(product);
         term_last_in = last;
         term_root_in = (op_mode_ff != MODE_DOT);
      end

      if (term_valid_ff && !term_last_ff) begin
         acc_in = sum;
      end

      if (cmd.finish) begin
         acc_in = '0;
         if (term_root_ff) begin
            rem_in  = sum;
            root_in = '0;
            bit_in  = ACC_WIDTH'(1) << (ACC_WIDTH - 2);
         end else begin
            result_in = sum;
         end
      end

      if (cmd.root_step) begin
         rem_in  = fits ? (rem_ff - trial) : rem_ff;
         root_in = root_next;
         bit_in  = bit_ff >> 2;
         if (bit_ff[0]) begin
            result_in = root_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_mode_ff    <= MODE_DIST;
         term_valid_ff <= 1'b0;
         acc_ff        <= '0;
      end else begin
         op_mode_ff    <= op_mode_in;
         term_valid_ff <= term_valid_in;
         acc_ff        <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      term_last_ff <= term_last_in;
      term_root_ff <= term_root_in;
      term_ff      <= term_in;
      rem_ff       <= rem_in;
      root_ff      <= root_in;
      bit_ff       <= bit_in;
      result_ff    <= result_in;
   end

   assign status.last_pending = term_valid_ff & term_last_ff;
   assign status.needs_root   = term_root_ff;
   assign status.root_last    = bit_ff[0];
   assign result              = result_ff;

endmodule

FILE: hw/rtl/vdd_ctrl.sv
// vdd_ctrl: sequencing of beat intake, square root iterations and result
// handoff. depends on vdd_pkg.

module vdd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  vdd_pkg::status_type  status,
   output vdd_pkg::cmd_type     cmd
);
   import vdd_pkg::*;

   localparam logic [1:0] ST_RUN  = 2'd0;
   localparam logic [1:0] ST_ROOT = 2'd1;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_free;
   logic       result_write;

   assign req_stall = (state_ff != ST_RUN) || status.last_pending;
   assign rsp_valid = rsp_valid_ff;
   // output register empty or emptied at this edge
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      cmd.accept    = req_valid && !req_stall;
      cmd.finish    = 1'b0;
      cmd.root_step = 1'b0;
      result_write  = 1'b0;
      unique case (state_ff)
         ST_RUN: begin
            if (status.last_pending) begin
               if (status.needs_root) begin
                  cmd.finish = 1'b1;
                  state_in   = ST_ROOT;
               end else if (rsp_free) begin
                  cmd.finish   = 1'b1;
                  result_write = 1'b1;
               end
            end
         end
         ST_ROOT: begin
            if (!status.root_last) begin
               cmd.root_step = 1'b1;
            end else if (rsp_free) begin
               cmd.root_step = 1'b1;
               result_write  = 1'b1;
               state_in      = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
      rsp_valid_in = result_write || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: hw/rtl/vector_distance_dot.sv
// vector_distance_dot: top level, joins the controller and the datapath.
// depends on vdd_pkg, vdd_ctrl and vdd_datapath.
//
// usage
//   req channel: one beat per component pair (req_comp_a, req_comp_b, signed
//   Q7.8); req_last closes the vector. rsp channel: one beat per vector,
//   rsp_result = dot product in Q.16 (mode 1) or floor square root of the
//   accumulated squares in Q.8 (mode 0 distance, modes 2 and 3 norm of a).
//   csr_we/csr_wdata set the mode; write only while no beat is in flight.
//   a mode change inside a vector applies to the pairs that follow it.
// throughput: one pair per cycle inside a vector, set by the single
//   multiplier followed by one accumulator add.
// after the closing beat its term waits in the term stage, then the final sum
//   goes to the result register for a dot product, or for distance and norm
//   through 21 square root iterations (one result bit each). req_stall is high
//   while the closing term waits and during the square root iterations.
// reset clears the mode to distance, the accumulator and all valids.
// while rsp_stall is high the result holds in the output register and pairs
//   of the next vector are still taken; its closing beat then holds req_stall
//   high until the output register is free.

module vector_distance_dot #(
   parameter int COMPONENT_WIDTH = vdd_pkg::COMPONENT_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [vdd_pkg::CSR_WIDTH-1:0]         csr_wdata,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [COMPONENT_WIDTH-1:0]     req_comp_a,
   input  logic signed [COMPONENT_WIDTH-1:0]     req_comp_b,
   input  logic                                  req_last,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [vdd_pkg::ACC_WIDTH-1:0]  rsp_result
);
   import vdd_pkg::*;

   cmd_type              cmd;
   status_type           status;
   logic [ACC_WIDTH-1:0] result;

   vdd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   vdd_datapath #(
      .COMPONENT_WIDTH (COMPONENT_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .comp_a    (req_comp_a),
      .comp_b    (req_comp_b),
      .last      (req_last),
      .cmd       (cmd),
      .status    (status),
      .result    (result)
   );

   assign rsp_result = $signed(result);

endmodule

FILE: hw/rtl/vdd_checker.sv
// vdd_checker: port level assertions for vector_distance_dot, attached by bind.
// depends on vdd_pkg and the top level's ports.

module vdd_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_stall,
   input logic                                  req_last,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic signed [vdd_pkg::ACC_WIDTH-1:0]  rsp_result
);

   // result beat holds while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_result))
      else $error("rsp_result changed while stalled");

   // closing beat blocks intake and cannot be answered in the next cycle
   a_close: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_last |=> req_stall && !$rose(rsp_valid))
      else $error("closing beat not followed by stall");

   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp_valid high right after reset");

endmodule

bind vector_distance_dot vdd_checker u_vdd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .req_last   (req_last),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_result (rsp_result)
);

FILE: dv/testbench.sv
// testbench for vector_distance_dot: drives component pair beats and mode writes,
// predicts distance, dot product and norm results, checks every result beat.
// depends on vdd_pkg and vector_distance_dot.
`timescale 1ns / 1ps

module testbench;
   import vdd_pkg::*;

   localparam logic [CSR_WIDTH-1:0] MODE_NORM_ALIAS = 2'd3;
   localparam int SETTLE_CYCLES = 30;
   localparam int RANDOM_BEATS  = 400;
   localparam int EXP_DEPTH     = 64;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         csr_we = 1'b0;
   logic [CSR_WIDTH-1:0]         csr_wdata = '0;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic signed [15:0]           req_comp_a = '0;
   logic signed [15:0]           req_comp_b = '0;
   logic                         req_last = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic signed [ACC_WIDTH-1:0]  rsp_result;

   logic [ACC_WIDTH-1:0]         running_sum = '0;
   logic [CSR_WIDTH-1:0]         mode_shadow = MODE_DIST;
   logic [ACC_WIDTH-1:0]         expected_mem [EXP_DEPTH];
   int                           exp_wr = 0;
   int                           exp_rd = 0;
   int                           error_count = 0;
   int                           beats_sent = 0;
   int                           hold_left = 0;
   bit                           no_idle = 1'b0;

   vector_distance_dot DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_comp_a (req_comp_a),
      .req_comp_b (req_comp_b),
      .req_last   (req_last),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (rsp_result)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("FAILURE");
      $finish;
   end

   function automatic logic [ACC_WIDTH-1:0] pair_term(logic [CSR_WIDTH-1:0] mode,
                                                      logic signed [15:0] a,
                                                      logic signed [15:0] b);
      logic signed [63:0] wa;
      logic signed [63:0] wb;
      logic signed [63:0] d;
      logic signed [63:0] p;
      wa = a;
      wb = b;
      if (mode == MODE_DOT) begin
         p = wa * wb;
      end else if (mode == MODE_DIST) begin
         d = wa - wb;
         p = d * d;
      end else begin
         p = wa * wa;
      end
      return p[ACC_WIDTH-1:0];
   endfunction

   function automatic logic [ACC_WIDTH-1:0] floor_root(logic [ACC_WIDTH-1:0] n);
      logic [63:0] root;
      logic [63:0] trial;
      logic [63:0] wide;
      wide = n;
      root = '0;
      for (int i = 20; i >= 0; i--) begin
         trial = root | (64'd1 << i);
         if (trial * trial <= wide) root = trial;
      end
      return root[ACC_WIDTH-1:0];
   endfunction

   function automatic logic signed [15:0] rand_comp();
      case ($urandom_range(15))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'sh0000;
         3: return -16'sd1;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic void add_expected(logic [ACC_WIDTH-1:0] value);
      expected_mem[exp_wr[5:0]] = value;
      exp_wr++;
   endfunction

   // predict on accepted request beats, check accepted result beats
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) mode_shadow = csr_wdata;
         if (req_valid && !req_stall) begin
            running_sum = running_sum + pair_term(mode_shadow, req_comp_a, req_comp_b);
            if (req_last) begin
               if (mode_shadow == MODE_DOT) add_expected(running_sum);
               else add_expected(floor_root(running_sum));
               running_sum = '0;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (exp_wr == exp_rd) begin
               $display("%0t unexpected result beat, expected none, actual %0d",
                        $time, rsp_result);
               error_count++;
            end else begin
               if (rsp_result !== expected_mem[exp_rd[5:0]]) begin
                  $display("%0t result mismatch, expected %0d, actual %0d",
                           $time, $signed(expected_mem[exp_rd[5:0]]), rsp_result);
                  error_count++;
               end
               exp_rd++;
            end
         end
      end
   end

   // result side back-pressure
   initial begin
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= !no_idle && ($urandom_range(99) < 29);
         end
      end
   end

   task automatic send_pair(logic signed [15:0] a, logic signed [15:0] b, logic last);
      @(negedge clock);
      while (!no_idle && $urandom_range(99) < 29) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_comp_a <= a;
      req_comp_b <= b;
      req_last   <= last;
      do @(posedge clock); while (req_stall);
      beats_sent++;
   endtask

   task automatic send_vector(int len);
      for (int i = 0; i < len; i++) send_pair(rand_comp(), rand_comp(), i == len - 1);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (exp_wr != exp_rd) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(logic [CSR_WIDTH-1:0] value);
      drain();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic test_reset_default();
      send_pair(16'sh7fff, 16'sh8000, 1'b1);
   endtask

   task automatic test_distance_extremes();
      write_mode(MODE_DIST);
      send_pair(16'sh8000, 16'sh7fff, 1'b0);
      send_pair(16'sh0000, 16'sh0000, 1'b1);
      send_pair(16'sh7fff, 16'sh7fff, 1'b1);
      send_pair(16'sh0100, -16'sh0100, 1'b0);
      send_pair(16'sh0003, 16'sh0001, 1'b1);
   endtask

   task automatic test_dot_product();
      write_mode(MODE_DOT);
      send_pair(16'sh8000, 16'sh8000, 1'b1);
      send_pair(16'sh8000, 16'sh7fff, 1'b1);
      send_pair(16'sh7fff, -16'sd1, 1'b0);
      send_pair(16'sd1, 16'sd1, 1'b1);
      send_pair(16'sh0000, 16'sh7fff, 1'b1);
   endtask

   task automatic test_norm_modes();
      write_mode(MODE_NORM);
      send_pair(16'sh8000, 16'sd12345, 1'b1);
      send_pair(16'sh0000, -16'sd1, 1'b1);
      write_mode(MODE_NORM_ALIAS);
      send_pair(16'sd100, 16'sd5, 1'b0);
      send_pair(-16'sd200, 16'sh8000, 1'b1);
   endtask

   // mode switched while a vector is open
   task automatic test_mode_switch_open_vector();
      write_mode(MODE_DIST);
      send_pair(16'sd1000, -16'sd1000, 1'b0);
      write_mode(MODE_DOT);
      send_pair(16'sd300, 16'sd400, 1'b1);
      send_pair(16'sd7, -16'sd9, 1'b0);
      write_mode(MODE_NORM);
      send_pair(16'sh7fff, 16'sd3, 1'b1);
   endtask

   // more pairs than the maximum dimension wrap the sum
   task automatic test_overlong_vector();
      write_mode(MODE_DIST);
      for (int i = 0; i < 1030; i++) send_pair(16'sh7fff, 16'sh8000, i == 1029);
   endtask

   task automatic test_full_rate();
      no_idle = 1'b1;
      write_mode(MODE_DOT);
      for (int v = 0; v < 20; v++) send_vector(int'($urandom_range(1, 12)));
      write_mode(MODE_DIST);
      for (int v = 0; v < 20; v++) send_vector(int'($urandom_range(1, 12)));
      drain();
      no_idle = 1'b0;
   endtask

   task automatic test_result_hold_off();
      write_mode(MODE_NORM);
      hold_left = 250;
      for (int v = 0; v < 12; v++) send_vector(int'($urandom_range(1, 3)));
   endtask

   task automatic test_random_vectors();
      int stop_at;
      int pick;
      stop_at = beats_sent + RANDOM_BEATS;
      while (beats_sent < stop_at) begin
         if ($urandom_range(4) == 0) write_mode(CSR_WIDTH'($urandom_range(3)));
         pick = int'($urandom_range(99));
         if (pick < 70) send_vector(int'($urandom_range(1, 6)));
         else if (pick < 95) send_vector(int'($urandom_range(7, 32)));
         else send_vector(int'($urandom_range(33, 200)));
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_default();
      test_distance_extremes();
      test_dot_product();
      test_norm_modes();
      test_mode_switch_open_vector();
      test_overlong_vector();
      test_full_rate();
      test_result_hold_off();
      test_random_vectors();
      drain();
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
